[rtl/odo_pkg.sv]
// Shared constants and sine-table/scaling helper functions for the odometry update block.
package odo_pkg;

   localparam int HEAD_W  = 13;
   localparam int DIST_W  = 32;
   localparam int POS_W   = 32;
   localparam int SCALE_W = 32;
   localparam int ROM_W   = 16;
   localparam int ACC_W   = 48;
   localparam int RES_W   = 49;

   localparam int TICKS_PER_TURN_DEF   = 4096;
   localparam int SINE_TABLE_DEPTH_DEF = 1024;

   localparam logic [SCALE_W-1:0] MM_PER_TICK_RST = 32'h0001_0000;

   localparam logic [63:0] Q30_ONE     = 64'd1073741824;
   localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

   // Q1.15 sine table entry. quad is the quarter of the turn, ang the Q30 angle
   // inside that quarter. Even quarters sum the sine series, odd ones the cosine.
   function automatic logic signed [ROM_W-1:0] sine_entry(input logic [1:0] quad,
                                                         input logic [63:0] ang);
      logic              odd;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic [63:0]        p;
      logic signed [63:0] sum;
      logic signed [63:0] v;
      odd  = ~quad[0];
      x2   = (ang * ang) >> 30;
      term = odd ? ang : Q30_ONE;
      sum  = $signed(term);
      p = (term * x2) >> 30;  term = odd ? p / 64'd6   : p / 64'd2;   sum = sum - $signed(term);
      p = (term * x2) >> 30;  term = odd ? p / 64'd20  : p / 64'd12;  sum = sum + $signed(term);
      p = (term * x2) >> 30;  term = odd ? p / 64'd42  : p / 64'd30;  sum = sum - $signed(term);
      p = (term * x2) >> 30;  term = odd ? p / 64'd72  : p / 64'd56;  sum = sum + $signed(term);
      p = (term * x2) >> 30;  term = odd ? p / 64'd110 : p / 64'd90;  sum = sum - $signed(term);
      p = (term * x2) >> 30;  term = odd ? p / 64'd156 : p / 64'd132; sum = sum + $signed(term);
      p = (term * x2) >> 30;  term = odd ? p / 64'd210 : p / 64'd182; sum = sum - $signed(term);
      if (sum < 0) begin
         sum = 64'sd0;
      end
      if (sum > $signed(Q30_ONE)) begin
         sum = $signed(Q30_ONE);
      end
      v = (sum * 64'sd32767 + 64'sd536870912) >>> 30;
      if (quad[1]) begin
         v = -v;
      end
      return v[ROM_W-1:0];
   endfunction

   // Saturate a scaled magnitude to the int32 range and restore the sign.
   function automatic logic [POS_W-1:0] scale_sat(input logic neg, input logic [RES_W-1:0] res);
      logic [RES_W-1:0] lim;
      logic [RES_W-1:0] lim_n;
      lim   = res;
      lim_n = '0;
      if (neg) begin
         if (res > RES_W'(64'h8000_0000)) begin
            lim = RES_W'(64'h8000_0000);
         end
         lim_n = RES_W'(0) - lim;
         return lim_n[POS_W-1:0];
      end
      if (res > RES_W'(64'h7FFF_FFFF)) begin
         lim = RES_W'(64'h7FFF_FFFF);
      end
      return lim[POS_W-1:0];
   endfunction

endpackage

[rtl/differential_odometry_update.sv]
// Dead-reckoning odometry update: heading/distance beats in, x/y position in millimetres out.
//
// Each request beat carries a heading in encoder ticks and the cumulative travelled distance.
// The block takes the distance step since the previous beat, folds the heading into one turn
// of TICKS_PER_TURN ticks, looks up sine and cosine in a Q1.15 sine ROM of SINE_TABLE_DEPTH
// entries, adds step*cos and step*sin to two 48-bit Q32.16 accumulators, and returns one
// response beat with both accumulators scaled by csr_mm_per_tick (Q16.16) and truncated
// toward zero, saturated to int32. One request gives exactly one response. The serial
// datapath holds two constant-reciprocal multiply steps to fold the heading and to map it
// onto a ROM index, two registered reads of the single-port sine ROM, the step products,
// the accumulator update, and the 48x32 scaling split into two partial products. req_stall
// stays high while an item is in flight. The response sits in an output register, so the
// next request is taken while a result still waits; the block only holds in its last step
// if the previous response has not been taken by then. csr_mm_per_tick is accepted only
// while no item is in flight.
module differential_odometry_update
   import odo_pkg::*;
#(
   parameter int TICKS_PER_TURN   = TICKS_PER_TURN_DEF,
   parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [HEAD_W-1:0]  req_heading_ticks,
   input  logic signed [DIST_W-1:0]  req_distance_ticks,
   // response channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [POS_W-1:0]   rsp_pos_x_mm,
   output logic signed [POS_W-1:0]   rsp_pos_y_mm,
   // scale register write channel
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [SCALE_W-1:0]        csr_mm_per_tick
);

   // ---------------------------------------------------------------------------------------
   // Derived constants
   // ---------------------------------------------------------------------------------------
   // Heading is offset by a whole number of turns so the fold works on a non-negative value.
   localparam int HEAD_HALF = 1 << (HEAD_W - 1);
   localparam int HP_OFFSET = TICKS_PER_TURN * ((HEAD_HALF + TICKS_PER_TURN - 1) / TICKS_PER_TURN);
   localparam int HP_MAX    = HEAD_HALF - 1 + HP_OFFSET;
   localparam int HP_W      = $clog2(HP_MAX + 1);
   localparam int TURN_W    = $clog2(TICKS_PER_TURN);
   localparam int PH_W      = TURN_W;
   localparam int Q1_W      = $clog2(HP_MAX / TICKS_PER_TURN + 1);

   // Exact floor division by TICKS_PER_TURN: m = floor(2^s/T)+1 with s = N + clog2(T).
   localparam int S1     = HP_W + TURN_W;
   localparam int M1_W   = HP_W + 2;
   localparam int PR1_W  = HP_W + M1_W;
   localparam logic [M1_W-1:0] M1 = M1_W'((64'd1 << S1) / TICKS_PER_TURN + 64'd1);

   localparam longint unsigned P_MAX =
      (longint'(TICKS_PER_TURN) - 1) * longint'(SINE_TABLE_DEPTH);
   localparam int P_W    = $clog2(P_MAX + 1);
   localparam int S2     = P_W + TURN_W;
   localparam int M2_W   = P_W + 2;
   localparam int PR2_W  = P_W + M2_W;
   localparam logic [M2_W-1:0] M2 = M2_W'((64'd1 << S2) / TICKS_PER_TURN + 64'd1);

   localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH);
   localparam int COS_OFF = SINE_TABLE_DEPTH / 4;

   // ---------------------------------------------------------------------------------------
   // Sine ROM contents, built at elaboration
   // ---------------------------------------------------------------------------------------
   typedef logic signed [ROM_W-1:0] sine_tbl_type [SINE_TABLE_DEPTH];

   function automatic sine_tbl_type build_sine_tbl();
      sine_tbl_type tbl;
      logic [63:0]  quad;
      logic [63:0]  rem;
      logic [63:0]  ang;
      for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
         quad   = (64'(i) * 64'd4) / SINE_TABLE_DEPTH;
         rem    = (64'(i) * 64'd4) % SINE_TABLE_DEPTH;
         ang    = (Q30_HALF_PI * rem) / SINE_TABLE_DEPTH;
         tbl[i] = sine_entry(quad[1:0], ang);
      end
      return tbl;
   endfunction

   localparam sine_tbl_type SINE_TBL = build_sine_tbl();

   // ---------------------------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------------------------
   typedef enum logic [11:0] {
      S_IDLE   = 12'b0000_0000_0001,
      S_QUOT   = 12'b0000_0000_0010,  // turns in heading, distance step
      S_PHASE  = 12'b0000_0000_0100,  // heading folded into one turn
      S_PDEP   = 12'b0000_0000_1000,  // phase times table depth
      S_INDEX  = 12'b0000_0001_0000,  // ROM index
      S_RD_SIN = 12'b0000_0010_0000,  // ROM read at index
      S_RD_COS = 12'b0000_0100_0000,  // ROM read a quarter turn on
      S_MULT   = 12'b0000_1000_0000,  // step products
      S_ACCUM  = 12'b0001_0000_0000,  // accumulator update
      S_ABSV   = 12'b0010_0000_0000,  // magnitudes
      S_SCALE  = 12'b0100_0000_0000,  // partial products with scale
      S_SUM    = 12'b1000_0000_0000   // combine, saturate, load response
   } state_type;

   state_type state_ff, state_in;

   // architectural state
   logic [SCALE_W-1:0]       mm_ff;
   logic [DIST_W-1:0]        last_ff;
   logic [ACC_W-1:0]         acc_x_ff, acc_y_ff;

   // working registers
   logic [HP_W-1:0]          hp_ff;
   logic [DIST_W-1:0]        dist_ff;
   logic [Q1_W-1:0]          q1_ff;
   logic signed [DIST_W-1:0] step_ff;
   logic [PH_W-1:0]          phase_ff;
   logic [P_W-1:0]           pd_ff;
   logic [IDX_W-1:0]         idx_ff;
   logic signed [ROM_W-1:0]  rom_q_ff;
   logic signed [ROM_W-1:0]  sin_ff;
   logic signed [ACC_W-1:0]  prod_x_ff, prod_y_ff;
   logic [ACC_W-1:0]         mag_x_ff, mag_y_ff;
   logic                     neg_x_ff, neg_y_ff;
   logic [63:0]              plo_x_ff, plo_y_ff;
   logic [ACC_W-1:0]         phi_x_ff, phi_y_ff;
   logic                     rsp_valid_ff;
   logic [POS_W-1:0]         pos_x_ff, pos_y_ff;

   // next values and datapath terms
   logic signed [31:0]       hp_sum;
   logic [HP_W-1:0]          hp_in;
   logic [PR1_W-1:0]         prod1;
   logic [Q1_W-1:0]          q1_in;
   logic [31:0]              ph_full;
   logic [PH_W-1:0]          phase_in;
   logic [63:0]              pd_full;
   logic [P_W-1:0]           pd_in;
   logic [PR2_W-1:0]         prod2;
   logic [IDX_W-1:0]         idx_in;
   logic [IDX_W:0]           cos_sum;
   logic [IDX_W-1:0]         cidx;
   logic [IDX_W-1:0]         rom_addr;
   logic [ACC_W-1:0]         acc_x_in, acc_y_in;
   logic [RES_W-1:0]         res_x, res_y;
   logic                     out_free;
   logic                     req_take;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_pos_x_mm = pos_x_ff;
   assign rsp_pos_y_mm = pos_y_ff;

   // heading offset by whole turns, never negative
   assign hp_sum = 32'(req_heading_ticks) + 32'(HP_OFFSET);
   assign hp_in  = hp_sum[HP_W-1:0];

   // whole turns in the offset heading, then the phase inside one turn
   assign prod1    = PR1_W'(hp_ff) * PR1_W'(M1);
   assign q1_in    = prod1[S1 +: Q1_W];
   assign ph_full  = 32'(hp_ff) - 32'(q1_ff) * 32'(TICKS_PER_TURN);
   assign phase_in = ph_full[PH_W-1:0];

   // index = floor(phase * depth / turn)
   assign pd_full = 64'(phase_ff) * 64'(SINE_TABLE_DEPTH);
   assign pd_in   = pd_full[P_W-1:0];
   assign prod2   = PR2_W'(pd_ff) * PR2_W'(M2);
   assign idx_in  = prod2[S2 +: IDX_W];

   // cosine sits a quarter of the table further on, wrapping once at most
   assign cos_sum = {1'b0, idx_ff} + (IDX_W + 1)'(COS_OFF);

   always_comb begin
      if (cos_sum >= (IDX_W + 1)'(SINE_TABLE_DEPTH)) begin
         cidx = IDX_W'(cos_sum - (IDX_W + 1)'(SINE_TABLE_DEPTH));
      end else begin
         cidx = cos_sum[IDX_W-1:0];
      end
   end

   assign rom_addr = (state_ff == S_RD_SIN) ? idx_ff : cidx;

   // Q.15 products doubled into Q.16, accumulators wrap in 48 bits
   assign acc_x_in = acc_x_ff + ACC_W'(prod_x_ff <<< 1);
   assign acc_y_in = acc_y_ff + ACC_W'(prod_y_ff <<< 1);

   // mag * scale / 2^32 = hi*scale + (lo*scale >> 32)
   assign res_x = RES_W'(phi_x_ff) + RES_W'(plo_x_ff[63:32]);
   assign res_y = RES_W'(phi_y_ff) + RES_W'(plo_y_ff[63:32]);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_QUOT;
            end
         end
         S_QUOT:   state_in = S_PHASE;
         S_PHASE:  state_in = S_PDEP;
         S_PDEP:   state_in = S_INDEX;
         S_INDEX:  state_in = S_RD_SIN;
         S_RD_SIN: state_in = S_RD_COS;
         S_RD_COS: state_in = S_MULT;
         S_MULT:   state_in = S_ACCUM;
         S_ACCUM:  state_in = S_ABSV;
         S_ABSV:   state_in = S_SCALE;
         S_SCALE:  state_in = S_SUM;
         S_SUM: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   // sine ROM, registered read
   always_ff @(posedge clock) begin
      rom_q_ff <= SINE_TBL[rom_addr];
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         mm_ff        <= MM_PER_TICK_RST;
         last_ff      <= '0;
         acc_x_ff     <= '0;
         acc_y_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            mm_ff <= csr_mm_per_tick;
         end
         if (state_ff == S_QUOT) begin
            last_ff <= dist_ff;
         end
         if (state_ff == S_ACCUM) begin
            acc_x_ff <= acc_x_in;
            acc_y_ff <= acc_y_in;
         end
         if (state_ff == S_SUM && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         hp_ff   <= hp_in;
         dist_ff <= req_distance_ticks;
      end
      if (state_ff == S_QUOT) begin
         q1_ff   <= q1_in;
         step_ff <= dist_ff - last_ff;
      end
      if (state_ff == S_PHASE) begin
         phase_ff <= phase_in;
      end
      if (state_ff == S_PDEP) begin
         pd_ff <= pd_in;
      end
      if (state_ff == S_INDEX) begin
         idx_ff <= idx_in;
      end
      if (state_ff == S_RD_COS) begin
         sin_ff <= rom_q_ff;
      end
      if (state_ff == S_MULT) begin
         prod_x_ff <= ACC_W'(step_ff) * ACC_W'(rom_q_ff);
         prod_y_ff <= ACC_W'(step_ff) * ACC_W'(sin_ff);
      end
      if (state_ff == S_ABSV) begin
         neg_x_ff <= acc_x_ff[ACC_W-1];
         neg_y_ff <= acc_y_ff[ACC_W-1];
         mag_x_ff <= acc_x_ff[ACC_W-1] ? ACC_W'(0) - acc_x_ff : acc_x_ff;
         mag_y_ff <= acc_y_ff[ACC_W-1] ? ACC_W'(0) - acc_y_ff : acc_y_ff;
      end
      if (state_ff == S_SCALE) begin
         plo_x_ff <= 64'(mag_x_ff[31:0]) * 64'(mm_ff);
         plo_y_ff <= 64'(mag_y_ff[31:0]) * 64'(mm_ff);
         phi_x_ff <= ACC_W'(mag_x_ff[ACC_W-1:32]) * ACC_W'(mm_ff);
         phi_y_ff <= ACC_W'(mag_y_ff[ACC_W-1:32]) * ACC_W'(mm_ff);
      end
      if (state_ff == S_SUM && out_free) begin
         pos_x_ff <= scale_sat(neg_x_ff, res_x);
         pos_y_ff <= scale_sat(neg_y_ff, res_y);
      end
   end

endmodule
